[hw/rtl/ebas_pkg.sv]
// Package for the eased box animation step unit.
// Holds request codes, state machine type, widths and controller/datapath structs.
`default_nettype none
package ebas_pkg;
    localparam int CURVE_POINTS_DEF = 64;
    localparam int PROG_W = 17;
    localparam int FACT_W = 18;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_START = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH,
        ST_FETCH,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_box;
        logic div_start;
        logic search_init;
        logic search_step;
        logic mul_step;
        logic out_load;
        logic out_idle;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic search_done;
        logic mul_done;
    } t_status;
endpackage
`default_nettype wire

[hw/rtl/ebas_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ebas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/ebas_ctrl.sv]
// Controller state machine of the eased box animation step unit.
// Depends on ebas_pkg.
`default_nettype none
module ebas_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_req,
    input  wire ebas_pkg::t_req    i_req_type,
    input  wire logic              i_running,
    input  wire logic              i_out_free,
    input  wire ebas_pkg::t_status i_status,
    output logic                   o_in_ready,
    output ebas_pkg::t_cmd         o_cmd
);
    ebas_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ebas_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ebas_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_req && i_req_type == ebas_pkg::REQ_TICK) begin
                    o_cmd.load_box = 1'b1;
                    if (i_running) begin
                        o_cmd.div_start = 1'b1;
                        n_state = ebas_pkg::ST_DIV;
                    end else begin
                        o_cmd.out_idle = 1'b1;
                        n_state = ebas_pkg::ST_OUT;
                    end
                end
            end
            ebas_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.search_init = 1'b1;
                    n_state = ebas_pkg::ST_SEARCH;
                end
            end
            ebas_pkg::ST_SEARCH: begin
                if (i_status.search_done) begin
                    n_state = ebas_pkg::ST_FETCH;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            ebas_pkg::ST_FETCH: begin
                n_state = ebas_pkg::ST_MUL;
            end
            ebas_pkg::ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_done) begin
                    n_state = ebas_pkg::ST_OUT;
                end
            end
            ebas_pkg::ST_OUT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ebas_pkg::ST_IDLE;
                end
            end
            default: n_state = ebas_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/ebas_dp.sv]
// Datapath of the eased box animation step unit: curve tables, frame state,
// serial divider, table search and shared multiplier. Depends on ebas_pkg, ebas_ram.
`default_nettype none
module ebas_dp #(
    parameter int CURVE_POINTS = ebas_pkg::CURVE_POINTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [15:0]                     i_cfg_data,
    input  wire logic                            i_in_req,
    input  wire ebas_pkg::t_req                  i_req_type,
    input  wire logic [5:0]                      i_point_index,
    input  wire logic [ebas_pkg::PROG_W-1:0]     i_point_progress,
    input  wire logic signed [ebas_pkg::FACT_W-1:0] i_point_factor,
    input  wire logic [123:0]                    i_box,
    input  wire ebas_pkg::t_cmd                  i_cmd,
    output ebas_pkg::t_status                    o_status,
    output logic                                 o_running,
    output logic [62:0]                          o_result
);
    localparam int AW = $clog2(CURVE_POINTS);

    logic [15:0] r_total, r_passed;
    logic        r_running;
    logic [123:0] r_box;

    // Serial restoring divider: (passed << 16) / total, 32-bit quotient.
    logic [31:0] r_quo;
    logic [16:0] r_rem;
    logic [5:0]  r_dcnt;
    logic        r_dbusy;
    logic [17:0] w_trial;
    logic [16:0] w_rem_sh;

    logic [AW-1:0] r_lo, r_hi;
    logic [ebas_pkg::PROG_W-1:0] w_prog_rd;
    logic signed [ebas_pkg::FACT_W-1:0] w_fact_rd;
    logic [AW-1:0] w_mid, w_raddr;
    logic          r_cmp_pend;
    logic [32:0]   w_progress;

    logic [2:0]  r_mcnt;
    logic signed [16:0] w_diff, w_base;
    logic signed [35:0] r_prod;
    logic        r_prod_v;
    logic [1:0]  r_fidx;
    logic signed [18:0] r_res [4];
    logic        r_more;
    logic        w_we;

    assign w_we = i_in_req && i_req_type == ebas_pkg::REQ_LOAD
                  && ({26'd0, i_point_index} < 32'(CURVE_POINTS));
    assign w_mid = AW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign w_raddr = (i_cmd.search_step && !r_cmp_pend) ? w_mid : r_hi;

    ebas_ram #(.WIDTH(ebas_pkg::PROG_W), .DEPTH(CURVE_POINTS)) u_prog_ram (
        .i_clk, .i_we(w_we), .i_waddr(AW'(i_point_index)), .i_wdata(i_point_progress),
        .i_raddr(w_raddr), .o_rdata(w_prog_rd)
    );
    ebas_ram #(.WIDTH(ebas_pkg::FACT_W), .DEPTH(CURVE_POINTS)) u_fact_ram (
        .i_clk, .i_we(w_we), .i_waddr(AW'(i_point_index)), .i_wdata(i_point_factor),
        .i_raddr(w_raddr), .o_rdata(w_fact_rd)
    );

    assign w_rem_sh = {r_rem[15:0], r_quo[31]};
    assign w_trial = {1'b0, w_rem_sh} - {2'b0, r_total};
    assign w_progress = (r_total == 16'd0) ? 33'd65536 : {1'b0, r_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= 16'd1;
            r_passed <= '0;
            r_running <= 1'b0;
            r_dbusy <= 1'b0;
            r_cmp_pend <= 1'b0;
            r_prod_v <= 1'b0;
            r_mcnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
            if (i_in_req && i_req_type == ebas_pkg::REQ_START) begin
                r_passed <= '0;
                r_running <= 1'b1;
            end
            if (i_cmd.load_box) begin
                r_box <= i_box;
            end
            if (i_cmd.div_start) begin
                r_quo <= {r_passed, 16'd0};
                r_rem <= '0;
                r_dcnt <= '0;
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                if (!w_trial[17]) begin
                    r_rem <= w_trial[16:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 6'd1;
                if (r_dcnt == 6'd31) begin
                    r_dbusy <= 1'b0;
                end
            end
            if (i_cmd.search_init) begin
                r_lo <= '0;
                r_hi <= AW'(CURVE_POINTS - 1);
                r_cmp_pend <= 1'b0;
            end else if (i_cmd.search_step) begin
                if (!r_cmp_pend) begin
                    r_cmp_pend <= 1'b1;
                end else begin
                    r_cmp_pend <= 1'b0;
                    if ({16'd0, w_prog_rd} <= w_progress) begin
                        r_lo <= w_mid;
                    end else begin
                        r_hi <= w_mid;
                    end
                end
            end
            if (i_cmd.search_init) begin
                if (w_progress >= 33'd65536) begin
                    r_running <= 1'b0;
                    r_more <= 1'b0;
                end else begin
                    r_passed <= r_passed + 16'd1;
                    r_more <= 1'b1;
                end
            end
            if (i_cmd.out_idle) begin
                r_more <= 1'b0;
                r_res[0] <= 19'(signed'(i_box[77:62]));
                r_res[1] <= 19'(signed'(i_box[93:78]));
                r_res[2] <= {4'b0, i_box[108:94]};
                r_res[3] <= {4'b0, i_box[123:109]};
            end
            // Four fields share one multiplier: select difference, multiply, then scale.
            if (i_cmd.mul_step) begin
                r_mcnt <= r_mcnt + 3'd1;
                r_prod_v <= 1'b1;
                r_fidx <= r_mcnt[1:0];
                r_prod <= w_diff * w_fact_rd;
                if (r_prod_v) begin
                    r_res[r_fidx] <= 19'(w_base) + 19'(r_prod / 36'sd65536);
                end
                if (r_mcnt == 3'd4) begin
                    r_mcnt <= '0;
                    r_prod_v <= 1'b0;
                end
            end else begin
                r_mcnt <= '0;
                r_prod_v <= 1'b0;
            end
        end
    end

    // Difference of the field entering the multiplier.
    always_comb begin
        logic signed [16:0] s, t;
        s = '0;
        t = '0;
        case (r_mcnt[1:0])
            2'd0: begin s = 17'(signed'(r_box[15:0]));  t = 17'(signed'(r_box[77:62])); end
            2'd1: begin s = 17'(signed'(r_box[31:16])); t = 17'(signed'(r_box[93:78])); end
            2'd2: begin s = {2'b0, r_box[46:32]};        t = {2'b0, r_box[108:94]}; end
            default: begin s = {2'b0, r_box[61:47]};     t = {2'b0, r_box[123:109]}; end
        endcase
        w_diff = t - s;
    end

    // Start value of the field whose product is being scaled.
    always_comb begin
        case (r_fidx)
            2'd0: w_base = 17'(signed'(r_box[15:0]));
            2'd1: w_base = 17'(signed'(r_box[31:16]));
            2'd2: w_base = {2'b0, r_box[46:32]};
            default: w_base = {2'b0, r_box[61:47]};
        endcase
    end

    function automatic logic [15:0] sat_s(input logic signed [18:0] v);
        if (v > 19'sd32767) return 16'h7FFF;
        if (v < -19'sd32768) return 16'h8000;
        return v[15:0];
    endfunction
    function automatic logic [14:0] sat_u(input logic signed [18:0] v);
        if (v > 19'sd32767) return 15'h7FFF;
        if (v < 19'sd0) return 15'd0;
        return v[14:0];
    endfunction

    assign o_running = r_running;
    assign o_status.div_done = !r_dbusy && !i_cmd.div_start;
    assign o_status.search_done = !r_cmp_pend && ((r_hi - r_lo) == AW'(1));
    assign o_status.mul_done = r_mcnt == 3'd4;
    assign o_result =
        {r_more, sat_u(r_res[3]), sat_u(r_res[2]), sat_s(r_res[1]), sat_s(r_res[0])};
endmodule
`default_nettype wire

[hw/rtl/eased_box_animation_step_unit.sv]
// A running tick passes through the serial divide, a bisection search of the curve
// table, a table fetch and the shared multiplier for the four fields; no new request is
// taken until its result is loaded. An idle tick skips those steps, load and start
// requests are taken in the idle state, and a stalled result holds input.
// Synchronous active-low reset clears control state, the frame counter and running,
// and sets the frame count to 1; the curve table is not cleared.
`default_nettype none
module eased_box_animation_step_unit #(
    parameter int CURVE_POINTS = ebas_pkg::CURVE_POINTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [15:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: point_index, point_progress, point_factor, start_x, start_y, start_w,
    // start_h, target_x, target_y, target_w, target_h, zero fill.
    input  wire logic [167:0] s_axis_tdata,
    // tuser: req_type.
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: box_x, box_y, box_w, box_h, more_frames, zero fill.
    output logic [63:0]       m_axis_tdata
);
    ebas_pkg::t_cmd    w_cmd;
    ebas_pkg::t_status w_status;
    logic w_in_req, w_running, r_valid, w_out_free;
    logic [62:0] w_res;
    logic [63:0] r_data;

    assign w_in_req = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_valid || m_axis_tready;

    ebas_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_req(w_in_req),
        .i_req_type(ebas_pkg::t_req'(s_axis_tuser)), .i_running(w_running),
        .i_out_free(w_out_free), .i_status(w_status),
        .o_in_ready(s_axis_tready), .o_cmd(w_cmd)
    );

    ebas_dp #(.CURVE_POINTS(CURVE_POINTS)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_in_req(w_in_req),
        .i_req_type(ebas_pkg::t_req'(s_axis_tuser)),
        .i_point_index(s_axis_tdata[5:0]), .i_point_progress(s_axis_tdata[22:6]),
        .i_point_factor(s_axis_tdata[40:23]), .i_box(s_axis_tdata[164:41]),
        .i_cmd(w_cmd), .o_status(w_status), .o_running(w_running), .o_result(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
        if (w_cmd.out_load) begin
            r_data <= {1'b0, w_res};
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata = r_data;
endmodule
`default_nettype wire
